FILE: hw/rtl/url_percent_decoder_core_macros.svh
// Assertion helpers shared by the decoder RTL.
// Each helper samples on the rising edge of clk and is disabled while rst is high.
`ifndef URL_PERCENT_DECODER_CORE_MACROS_SVH
`define URL_PERCENT_DECODER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define URLPD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define URLPD_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define URLPD_ASSERT(name, prop, msg)
`define URLPD_ASSERT_NEXT(name, pre, post, msg)
`endif
`endif

FILE: hw/rtl/urlpd_pkg.sv
package urlpd_pkg;

  localparam logic [7:0] PERCENT = 8'h25;

  // Escape progress, one-hot
  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_PCT   = 3'b010,
    PH_DIGIT = 3'b100
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } urlpd_item_t;

  typedef struct packed {
    logic [1:0]  cnt;
    urlpd_item_t item0;
    urlpd_item_t item1;
    phase_t      phase_next;
    logic [7:0]  held_next;
  } urlpd_step_t;

  // Hex digit value; anything that is not a hex digit counts as zero
  function automatic logic [3:0] hex_value(input logic [7:0] b);
    logic [3:0] v;
    v = 4'h0;
    if (b >= 8'h30 && b <= 8'h39) begin
      v = b[3:0];
    end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
      v = b[3:0] + 4'd9;
    end
    return v;
  endfunction

endpackage

FILE: hw/rtl/urlpd_out_fifo.sv
module urlpd_out_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [1:0]                   push_cnt,
  input  urlpd_pkg::urlpd_item_t       push0,
  input  urlpd_pkg::urlpd_item_t       push1,
  input  logic                         pop_ready,
  output logic                         head_valid,
  output urlpd_pkg::urlpd_item_t       head_item,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  urlpd_pkg::urlpd_item_t slots [DEPTH];
  logic [PW-1:0] head;
  logic [PW-1:0] tail;
  logic [PW-1:0] tail_plus1;
  logic [PW-1:0] tail_next;
  logic [CW-1:0] count_next;
  logic          pop;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign tail_plus1 = wrap_inc(tail);
  assign pop        = head_valid && pop_ready;
  assign head_valid = (count != '0);
  assign head_item  = slots[head];

  always_comb begin
    case (push_cnt)
      2'd1:    tail_next = tail_plus1;
      2'd2:    tail_next = wrap_inc(tail_plus1);
      default: tail_next = tail;
    endcase
    count_next = count + CW'(push_cnt) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      slots[tail] <= push0;
    end
    if (push_cnt == 2'd2) begin
      slots[tail_plus1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      tail  <= tail_next;
      count <= count_next;
      if (pop) begin
        head <= wrap_inc(head);
      end
    end
  end

endmodule

FILE: hw/rtl/urlpd_decode.sv
module urlpd_decode (
  input  urlpd_pkg::phase_t      phase,
  input  logic [7:0]             held,
  input  logic [7:0]             in_byte,
  input  logic                   in_last,
  output urlpd_pkg::urlpd_step_t step
);

  always_comb begin
    step            = '0;
    step.phase_next = urlpd_pkg::PH_IDLE;
    step.held_next  = 8'h00;
    case (phase)
      urlpd_pkg::PH_PCT: begin
        if (in_last) begin
          // string ends one byte after the percent: pass both through
          step.cnt   = 2'd2;
          step.item0 = '{data: urlpd_pkg::PERCENT, last: 1'b0};
          step.item1 = '{data: in_byte, last: 1'b1};
        end else begin
          step.held_next  = in_byte;
          step.phase_next = urlpd_pkg::PH_DIGIT;
        end
      end
      urlpd_pkg::PH_DIGIT: begin
        step.cnt   = 2'd1;
        step.item0 = '{data: {urlpd_pkg::hex_value(held), urlpd_pkg::hex_value(in_byte)},
                       last: in_last};
      end
      default: begin
        if (in_byte == urlpd_pkg::PERCENT && !in_last) begin
          step.phase_next = urlpd_pkg::PH_PCT;
        end else begin
          step.cnt   = 2'd1;
          step.item0 = '{data: in_byte, last: in_last};
        end
      end
    endcase
  end

endmodule

FILE: hw/rtl/url_percent_decoder_core.sv
// URL percent decoder, streaming.
// Slave channel s_axis_*: one encoded byte per request, tlast on the final byte
// of a string. Master channel m_axis_*: decoded bytes, tlast on the final
// decoded byte of the string. "%hh" collapses to one byte; non-hex digits
// count as zero; a '%' that ends a string passes through, and a string that
// ends one byte after a '%' passes the '%' and that byte through unchanged.
// Throughput: one request per cycle, sustained, while the receiver keeps up.
// An input register feeds the decode logic, whose results land in an output
// queue of OUT_DEPTH entries; a request is decoded only when two slots are
// free, so the end-of-string flush that yields two results never overflows.
// When the receiver stalls the queue fills, then the input register holds
// and s_axis_tready drops; nothing is lost or repeated.
// Reset (rst, synchronous, active high) empties the queue and the input
// register and returns the decoder to the between-escapes state.
`include "url_percent_decoder_core_macros.svh"

module url_percent_decoder_core #(
  parameter int OUT_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // in_last
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast    // out_last
);

  localparam int CW = $clog2(OUT_DEPTH + 1);

  // input register
  logic       q_valid;
  logic [7:0] q_byte;
  logic       q_last;

  // decoder state
  urlpd_pkg::phase_t phase;
  logic [7:0]        held;

  urlpd_pkg::urlpd_step_t step;
  urlpd_pkg::urlpd_item_t head_item;
  logic [CW-1:0]          fifo_count;
  logic                   consume;
  logic [1:0]             push_cnt;

  // decode only with room for the two-result flush
  assign consume       = q_valid && (fifo_count <= CW'(OUT_DEPTH - 2));
  assign s_axis_tready = !q_valid || consume;
  assign push_cnt      = consume ? step.cnt : 2'd0;

  urlpd_decode u_decode (
    .phase   (phase),
    .held    (held),
    .in_byte (q_byte),
    .in_last (q_last),
    .step    (step)
  );

  urlpd_out_fifo #(
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_cnt   (push_cnt),
    .push0      (step.item0),
    .push1      (step.item1),
    .pop_ready  (m_axis_tready),
    .head_valid (m_axis_tvalid),
    .head_item  (head_item),
    .count      (fifo_count)
  );

  assign m_axis_tdata = head_item.data;
  assign m_axis_tlast = head_item.last;

  // hold the payload until it is decoded; load a fresh request whenever taken
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      q_byte <= s_axis_tdata;
      q_last <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
      phase   <= urlpd_pkg::PH_IDLE;
      held    <= 8'h00;
    end else begin
      if (s_axis_tready) begin
        q_valid <= s_axis_tvalid;
      end
      // advance the escape state only on a decoded request
      if (consume) begin
        phase <= step.phase_next;
        held  <= step.held_next;
      end
    end
  end

  `URLPD_ASSERT(a_fifo_bound, fifo_count <= CW'(OUT_DEPTH), "output queue overflow")
  `URLPD_ASSERT(a_flush_order, (consume && step.cnt == 2'd2) |-> (!step.item0.last && step.item1.last), "flush tlast order wrong")
  `URLPD_ASSERT_NEXT(a_end_idle, consume && q_last, phase == urlpd_pkg::PH_IDLE, "escape state kept past end of string")
  `URLPD_ASSERT_NEXT(a_pct_enter, consume && phase == urlpd_pkg::PH_IDLE && q_byte == urlpd_pkg::PERCENT && !q_last, phase == urlpd_pkg::PH_PCT, "percent did not open an escape")

endmodule

FILE: sim/testbench.sv
module testbench;

  // One encoded byte on its way to the decoder, with the cycles the sender
  // idles before offering it and an optional hold until all results are back.
  typedef struct {
    logic [7:0]  raw;
    logic        ends;
    int unsigned gap;
    bit          drain;
  } request_t;

  localparam int STALL_LIMIT = 1000;   // cycles with no handshake at all
  localparam int LONG_HOLD   = 120;    // receiver hold-off, fills the output queue
  localparam int TAIL_CYCLES = 8;      // slack after the final result

  logic       clk;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;   // [7:0] in_byte
  logic       s_axis_tlast = 1'b0;    // in_last
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [7:0] out_byte
  logic       m_axis_tlast;           // out_last

  request_t               request_q[$];
  urlpd_pkg::urlpd_item_t decoded_q[$];

  // Predictor state, mirrors the decoder's escape tracking
  urlpd_pkg::phase_t esc_phase = urlpd_pkg::PH_IDLE;
  logic [7:0]        esc_first = 8'h00;

  int unsigned strings_sent    = 0;
  int unsigned requests_sent   = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches      = 0;
  int unsigned gap_count       = 0;
  int unsigned stall_left      = 0;
  int unsigned idle_cycles     = 0;
  bit          long_hold_done  = 1'b0;

  url_percent_decoder_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Value of one hex digit; every other byte counts as zero.
  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return 4'(c - 8'h30);
    if (c >= "A" && c <= "F") return 4'(c - 8'h41 + 8'd10);
    if (c >= "a" && c <= "f") return 4'(c - 8'h61 + 8'd10);
    return 4'h0;
  endfunction

  function automatic urlpd_pkg::urlpd_item_t mk_result(input logic [7:0] d, input logic l);
    urlpd_pkg::urlpd_item_t r;
    r.data = d;
    r.last = l;
    return r;
  endfunction

  // Append one expected decoded byte.
  function void expect_result(input logic [7:0] d, input logic l);
    decoded_q.insert(decoded_q.size(), mk_result(d, l));
  endfunction

  // Advance the escape tracker by one accepted request and queue the
  // decoded bytes that it produces.
  function void decode_byte(input logic [7:0] c, input logic l);
    case (esc_phase)
      urlpd_pkg::PH_PCT: begin
        if (l) begin
          // string ended one byte after '%': flush both literally
          expect_result(urlpd_pkg::PERCENT, 1'b0);
          expect_result(c, 1'b1);
          esc_phase = urlpd_pkg::PH_IDLE;
          esc_first = 8'h00;
        end else begin
          esc_first = c;
          esc_phase = urlpd_pkg::PH_DIGIT;
        end
      end
      urlpd_pkg::PH_DIGIT: begin
        expect_result({nibble_of(esc_first), nibble_of(c)}, l);
        esc_phase = urlpd_pkg::PH_IDLE;
        esc_first = 8'h00;
      end
      default: begin
        if (c == urlpd_pkg::PERCENT && !l) begin
          esc_phase = urlpd_pkg::PH_PCT;
        end else begin
          expect_result(c, l);
          esc_phase = urlpd_pkg::PH_IDLE;
        end
        esc_first = 8'h00;
      end
    endcase
  endfunction

  // Queue one request; gap_max of zero gives a back-to-back stretch.
  function void add_request(input logic [7:0] c, input logic l, input int unsigned gap_max,
                            input bit drain = 1'b0);
    request_t r;
    r.raw   = c;
    r.ends  = l;
    r.gap   = $urandom_range(0, gap_max);
    r.drain = drain;
    request_q.insert(request_q.size(), r);
    if (l) strings_sent++;
  endfunction

  // Queue a whole string, flagging its final byte.
  function void add_string(input string s);
    for (int i = 0; i < s.len(); i++) begin
      add_request(s[i], i == s.len() - 1, 8);
    end
  endfunction

  // Random byte biased toward escapes: '%', hex digits, or anything.
  function automatic logic [7:0] pick_byte();
    int unsigned sel;
    string digits;
    sel = $urandom_range(0, 9);
    digits = "0123456789abcdefABCDEF";
    if (sel < 3) return urlpd_pkg::PERCENT;
    if (sel < 7) return digits[$urandom_range(0, digits.len() - 1)];
    return 8'($urandom_range(0, 255));
  endfunction

  // Sender: hold the current request until it is taken, then idle for the
  // next request's gap. A request marked drain waits until every expected
  // result has come back before it is offered.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      gap_count     <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        decode_byte(s_axis_tdata, s_axis_tlast);
        requests_sent <= requests_sent + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (request_q.size() > 0 && gap_count >= request_q[0].gap &&
            !(request_q[0].drain && decoded_q.size() != 0)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= request_q[0].raw;
          s_axis_tlast  <= request_q[0].ends;
          void'(request_q.pop_front());
          gap_count     <= 0;
        end else begin
          s_axis_tvalid <= 1'b0;
          gap_count     <= gap_count + 1;
        end
      end
    end
  end

  // Receiver: check each result against the oldest expectation, then stall
  // for a random count. Once, drop ready for a long stretch so the output
  // queue fills and the decoder pushes back on its input; for a while in
  // the middle, never stall at all.
  always @(posedge clk) begin
    urlpd_pkg::urlpd_item_t want;
    int unsigned next_stall;
    int unsigned errs;
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
    end else begin
      next_stall = stall_left;
      errs       = 0;
      if (m_axis_tvalid && m_axis_tready) begin
        if (decoded_q.size() == 0) begin
          $error("unexpected result: out_byte %h, out_last %b", m_axis_tdata, m_axis_tlast);
          errs++;
        end else begin
          want = decoded_q.pop_front();
          if (m_axis_tdata !== want.data) begin
            $error("out_byte: expected %h, got %h", want.data, m_axis_tdata);
            errs++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("out_last: expected %b, got %b", want.last, m_axis_tlast);
            errs++;
          end
        end
        results_checked <= results_checked + 1;
        if (results_checked == 200 && !long_hold_done) begin
          next_stall = LONG_HOLD;
          long_hold_done <= 1'b1;
        end else if (results_checked >= 300 && results_checked < 400) begin
          next_stall = 0;
        end else begin
          next_stall = $urandom_range(0, 8);
        end
      end
      if (errs != 0) begin
        mismatches <= mismatches + errs;
      end
      if (next_stall > 0) begin
        m_axis_tready <= 1'b0;
        stall_left    <= next_stall - 1;
      end else begin
        m_axis_tready <= 1'b1;
        stall_left    <= 0;
      end
    end
  end

  // Count cycles in which neither side moves a request or a result.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
    $display("url_percent_decoder_core: mismatch");
    $finish;
  end

  initial begin
    int unsigned len;
    // Plain bytes at both extremes, then a byte ending the string.
    add_request(8'h00, 1'b0, 8);
    add_request(8'hff, 1'b0, 8);
    add_request("A", 1'b1, 8);
    // Full escape with the second digit as final byte.
    add_string("%41");
    // '%' alone as the final byte.
    add_string("%");
    // String ends right after the first digit: '%' and that byte pass through.
    add_string("%g");
    // Lower and upper case hex, then a plain tail.
    add_string("%fFx");
    // Bytes after a '%' are never a new escape; '%' itself counts as zero.
    add_string("%%%0");
    // Non-hex digit, and the top byte value held as first digit.
    add_string("%G9");
    add_request(urlpd_pkg::PERCENT, 1'b0, 8);
    add_request(8'hff, 1'b0, 8);
    add_request("a", 1'b1, 8);

    // Random strings, mostly escape-heavy, of 1 to 12 bytes.
    for (int n = 0; n < 530; n += len) begin
      len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        // a back-to-back stretch, and one or more pauses for a full drain
        add_request(pick_byte(), i == len - 1,
                    (n >= 150 && n < 250) ? 0 : 8,
                    n >= 350 && i == 0 && n < 362);
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (request_q.size() != 0 || s_axis_tvalid || decoded_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("sent %0d bytes in %0d strings, checked %0d decoded bytes",
             requests_sent, strings_sent, results_checked);
    $display("covered escapes, short-string flushes, output back-pressure and a full drain");
    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("url_percent_decoder_core: match");
    end else begin
      $display("url_percent_decoder_core: mismatch");
    end
    $finish;
  end

endmodule
